// ===== rtl/core/jwli_pkg.sv =====
package jwli_pkg;

  localparam int POS_W           = 12;
  localparam int IDX_W           = 6;
  localparam int NUM_JOINTS      = 4;
  localparam int SAMPLES_DEFAULT = 32;

  localparam int IN_TDATA_W  = ((NUM_JOINTS * POS_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = NUM_JOINTS * POS_W + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [NUM_JOINTS-1:0][POS_W-1:0] pos_arr_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
  } issue_t;

endpackage

// ===== rtl/core/jwli_lane.sv =====
module jwli_lane #(
  parameter int SAMPLES_PER_SEGMENT = jwli_pkg::SAMPLES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [jwli_pkg::POS_W-1:0] a,
  input  logic [jwli_pkg::POS_W-1:0] b,
  input  logic [jwli_pkg::IDX_W-1:0] idx,
  output logic [jwli_pkg::POS_W-1:0] q
);

  localparam int DEN    = SAMPLES_PER_SEGMENT - 1;
  localparam int WPROD  = jwli_pkg::POS_W + jwli_pkg::IDX_W;
  localparam int NUM_W  = jwli_pkg::POS_W + $clog2(SAMPLES_PER_SEGMENT);
  localparam int SHIFT  = NUM_W;
  localparam int MUL_W  = SHIFT + 1;
  localparam int PROD_W = NUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'((2 ** SHIFT) / DEN);
  localparam logic [jwli_pkg::IDX_W-1:0] DEN_IDX = jwli_pkg::IDX_W'(DEN);

  logic [jwli_pkg::IDX_W-1:0] wa;
  logic [WPROD-1:0]           pa;
  logic [WPROD-1:0]           pb;
  logic [NUM_W-1:0]           num1_nxt;
  logic [NUM_W-1:0]           num1_r;
  logic [NUM_W-1:0]           num2_r;
  logic [PROD_W-1:0]          prod_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic [jwli_pkg::POS_W-1:0] q_est;
  logic [NUM_W-1:0]           qd;
  logic [NUM_W-1:0]           rem;
  logic                       fix;

  // The weighted sum a*(S-1-j) + b*j is formed first, then divided by S-1
  // through a reciprocal multiply that may come out one low.
  assign wa       = DEN_IDX - idx;
  assign pa       = WPROD'(a) * WPROD'(wa);
  assign pb       = WPROD'(b) * WPROD'(idx);
  assign num1_nxt = NUM_W'(pa + pb);
  assign prod_nxt = PROD_W'(num1_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= num1_nxt;
      num2_r <= num1_r;
      prod_r <= prod_nxt;
    end
  end

  assign q_est = prod_r[SHIFT +: jwli_pkg::POS_W];
  assign qd    = NUM_W'(NUM_W'(q_est) * NUM_W'(DEN));
  assign rem   = num2_r - qd;
  assign fix   = rem >= NUM_W'(DEN);
  assign q     = q_est + jwli_pkg::POS_W'(fix);

endmodule

// ===== rtl/core/jwli_seq.sv =====
module jwli_seq #(
  parameter int SAMPLES_PER_SEGMENT = jwli_pkg::SAMPLES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  jwli_pkg::pos_arr_t in_pos,
  input  logic               adv,
  output jwli_pkg::issue_t   issue,
  output jwli_pkg::pos_arr_t seg_a,
  output jwli_pkg::pos_arr_t seg_b
);

  localparam logic [jwli_pkg::IDX_W-1:0] LAST_IDX =
    jwli_pkg::IDX_W'(SAMPLES_PER_SEGMENT - 1);

  logic                       busy_r;
  logic                       busy_nxt;
  logic                       have_prev_r;
  logic                       have_prev_nxt;
  logic [jwli_pkg::IDX_W-1:0] j_r;
  logic [jwli_pkg::IDX_W-1:0] j_nxt;
  jwli_pkg::pos_arr_t         seg_a_r;
  jwli_pkg::pos_arr_t         seg_b_r;
  logic                       fire;
  logic                       last_fire;
  logic                       acc;
  logic                       seg_start;

  assign fire      = busy_r && adv;
  assign last_fire = fire && (j_r == LAST_IDX);
  assign in_tready = !busy_r || last_fire;
  assign acc       = in_tvalid && in_tready;
  assign seg_start = acc && !in_tuser && have_prev_r;

  always_comb begin
    busy_nxt      = busy_r;
    j_nxt         = j_r;
    have_prev_nxt = have_prev_r || acc;
    if (fire) begin
      j_nxt = (j_r == LAST_IDX) ? '0 : j_r + 1'b1;
    end
    if (last_fire) begin
      busy_nxt = 1'b0;
    end
    if (seg_start) begin
      busy_nxt = 1'b1;
      j_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      have_prev_r <= 1'b0;
      j_r         <= '0;
    end else begin
      busy_r      <= busy_nxt;
      have_prev_r <= have_prev_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      seg_b_r <= in_pos;
    end
    if (seg_start) begin
      seg_a_r <= seg_b_r;
    end
  end

  assign issue.valid = fire;
  assign issue.idx   = j_r;
  assign issue.last  = j_r == LAST_IDX;
  assign seg_a       = seg_a_r;
  assign seg_b       = seg_b_r;

endmodule

// ===== rtl/core/jwli_merge.sv =====
module jwli_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  jwli_pkg::issue_t                    issue,
  input  jwli_pkg::pos_arr_t                  lane_q,
  output logic                                adv,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [jwli_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int PAD_W = jwli_pkg::OUT_TDATA_W - jwli_pkg::OUT_FIELD_W;

  jwli_pkg::issue_t           s1_r;
  jwli_pkg::issue_t           s2_r;
  logic                       out_valid_r;
  jwli_pkg::pos_arr_t         out_pos_r;
  logic [jwli_pkg::IDX_W-1:0] out_idx_r;
  logic                       out_last_r;

  // Every stage moves together whenever the output register is free or drained.
  assign adv = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_r        <= issue;
      s2_r        <= s1_r;
      out_valid_r <= s2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r  <= lane_q;
      out_idx_r  <= s2_r.idx;
      out_last_r <= s2_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_idx_r, out_pos_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/joint_waypoint_linear_interpolator_core.sv =====
// Linear waypoint interpolator for four joints. The first waypoint after reset,
// and any waypoint with in_tuser set, is stored and yields no result; each other
// waypoint yields SAMPLES_PER_SEGMENT results stepping from the stored waypoint
// to the new one, both ends included, each position being
// floor((a*(S-1-j) + b*j) / (S-1)). One result leaves per cycle while the
// output is not stalled by out_tready; a waypoint that opens a segment holds
// the input until its final sample issues, and the next waypoint is taken in
// the cycle of that final sample. A store-only waypoint does not hold the input.
// The first result passes the two lane stages and then the output register.
module joint_waypoint_linear_interpolator_core #(
  parameter int SAMPLES_PER_SEGMENT = jwli_pkg::SAMPLES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // joint0_target, joint1_target, joint2_target, gripper_target
  input  logic [jwli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // new_path
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // joint0_pos, joint1_pos, joint2_pos, gripper_pos, sample_index, zero pad
  output logic [jwli_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  jwli_pkg::pos_arr_t in_pos;
  jwli_pkg::pos_arr_t seg_a;
  jwli_pkg::pos_arr_t seg_b;
  jwli_pkg::pos_arr_t lane_q;
  jwli_pkg::issue_t   issue;
  logic               adv;

  assign in_pos = jwli_pkg::pos_arr_t'(in_tdata[jwli_pkg::NUM_JOINTS*jwli_pkg::POS_W-1:0]);

  jwli_seq #(
    .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_pos    (in_pos),
    .adv       (adv),
    .issue     (issue),
    .seg_a     (seg_a),
    .seg_b     (seg_b)
  );

  for (genvar k = 0; k < jwli_pkg::NUM_JOINTS; k++) begin : g_lane
    jwli_lane #(
      .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT)
    ) u_lane (
      .clk (clk),
      .en  (adv),
      .a   (seg_a[k]),
      .b   (seg_b[k]),
      .idx (issue.idx),
      .q   (lane_q[k])
    );
  end

  jwli_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .lane_q     (lane_q),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import jwli_pkg::*;

  localparam int SEG_SAMPLES = SAMPLES_DEFAULT;
  localparam int RANDOM_WAYPOINTS = 200;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    pos_arr_t         pos;
    logic [IDX_W-1:0] idx;
    logic             last;
  } sample_t;

  class waypoint_scoreboard;
    sample_t  expected_samples[$];
    pos_arr_t stored_waypoint;
    bit       have_stored;
    int       mismatches;
    int       samples_checked;
    int       segments;
    int       stores;

    function new();
      stored_waypoint = '0;
      have_stored = 1'b0;
      mismatches = 0;
      samples_checked = 0;
      segments = 0;
      stores = 0;
    endfunction

    function logic [POS_W-1:0] interp_joint(int unsigned a, int unsigned b, int unsigned j);
      int unsigned span;
      int unsigned weighted;
      span = SEG_SAMPLES - 1;
      weighted = a * (span - j) + b * j;
      return POS_W'(weighted / span);
    endfunction

    function void take_waypoint(bit new_path, pos_arr_t target);
      sample_t s;
      if (!new_path && have_stored) begin
        for (int j = 0; j < SEG_SAMPLES; j++) begin
          for (int k = 0; k < NUM_JOINTS; k++) begin
            s.pos[k] = interp_joint(stored_waypoint[k], target[k], j);
          end
          s.idx = IDX_W'(j);
          s.last = (j == SEG_SAMPLES - 1);
          expected_samples = {expected_samples, s};
        end
        segments++;
      end else begin
        stores++;
      end
      stored_waypoint = target;
      have_stored = 1'b1;
    endfunction

    task report_mismatch(string field, int got, int want);
      $display("Mismatch on %s: got %0d, expected %0d (sample %0d)", field, got, want,
               samples_checked);
      mismatches++;
    endtask

    task check_sample(logic [OUT_TDATA_W-1:0] data, logic last);
      sample_t  want;
      pos_arr_t got_pos;
      logic [IDX_W-1:0] got_idx;
      got_pos = data[NUM_JOINTS*POS_W-1:0];
      got_idx = data[NUM_JOINTS*POS_W +: IDX_W];
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected transfer, index", int'(got_idx), -1);
      end else begin
        want = expected_samples.pop_front();
        for (int k = 0; k < NUM_JOINTS; k++) begin
          if (got_pos[k] !== want.pos[k]) begin
            report_mismatch($sformatf("joint %0d position", k), int'(got_pos[k]),
                            int'(want.pos[k]));
          end
        end
        if (got_idx !== want.idx) begin
          report_mismatch("sample_index", int'(got_idx), int'(want.idx));
        end
        if (last !== want.last) begin
          report_mismatch("last_sample", int'(last), int'(want.last));
        end
      end
      samples_checked++;
    endtask

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  waypoint_scoreboard sb;
  int idle_cycles = 0;

  joint_waypoint_linear_interpolator_core #(
    .SAMPLES_PER_SEGMENT(SEG_SAMPLES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_sample(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: stall patterns of varying density, plus one long hold-off that
  // backs the block up while the sender keeps offering waypoints.
  initial begin
    int  mode;
    int  span;
    int  phase;
    bit  held_off;
    held_off = 1'b0;
    phase = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && sb.samples_checked >= 120) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= (phase % 3 != 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  task drive_waypoint(input bit new_path, input int j0, input int j1, input int j2,
                      input int j3);
    pos_arr_t target;
    target[0] = POS_W'(j0);
    target[1] = POS_W'(j1);
    target[2] = POS_W'(j2);
    target[3] = POS_W'(j3);
    in_tvalid <= 1'b1;
    in_tuser <= new_path;
    in_tdata <= target;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_waypoint(new_path, target);
  endtask

  task idle_sender(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function int pick_position(int prev);
    int lo;
    int hi;
    lo = (prev > 40) ? prev - 40 : 0;
    hi = (prev < 4055) ? prev + 40 : 4095;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(lo, hi);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  initial begin
    int burst;
    int sent;
    int p0, p1, p2, p3;
    bit np;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed waypoints: no stored waypoint after reset, full-scale ramps in
    // both directions, flat segments, new paths after a segment and back to back,
    // alternating bit patterns, mixed directions and single-step deltas.
    drive_waypoint(1'b0, 0, 0, 0, 0);
    drive_waypoint(1'b0, 4095, 4095, 4095, 4095);
    drive_waypoint(1'b0, 0, 0, 0, 0);
    drive_waypoint(1'b0, 0, 0, 0, 0);
    drive_waypoint(1'b1, 4095, 4095, 4095, 4095);
    drive_waypoint(1'b0, 4095, 4095, 4095, 4095);
    drive_waypoint(1'b0, 'hAAA, 'h555, 'hAAA, 'h555);
    drive_waypoint(1'b0, 'h555, 'hAAA, 'h555, 'hAAA);
    drive_waypoint(1'b0, 0, 4095, 1, 4094);
    drive_waypoint(1'b1, 123, 2047, 2048, 3000);
    drive_waypoint(1'b1, 7, 8, 9, 10);
    drive_waypoint(1'b0, 38, 39, 71, 10);
    drive_waypoint(1'b0, 37, 40, 70, 9);
    drive_waypoint(1'b0, 4095, 0, 4095, 0);

    // Random waypoints in bursts; mostly continuing segments, some new paths.
    sent = 0;
    p0 = 0; p1 = 0; p2 = 0; p3 = 0;
    while (sent < RANDOM_WAYPOINTS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < RANDOM_WAYPOINTS) begin
          np = ($urandom_range(0, 6) == 0);
          p0 = pick_position(p0);
          p1 = pick_position(p1);
          p2 = pick_position(p2);
          p3 = pick_position(p3);
          drive_waypoint(np, p0, p1, p2, p3);
          sent++;
          if (sent == RANDOM_WAYPOINTS / 2) begin
            in_tvalid <= 1'b0;
            do begin
              @(posedge clk);
            end while (sb.pending() != 0);
          end
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 40));
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d waypoints: %0d store-only, %0d segments, %0d samples checked.",
             sb.stores + sb.segments, sb.stores, sb.segments, sb.samples_checked);
    $display("Receiver stalls included a %0d-cycle hold-off; %0d mismatches.", LONG_HOLD,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
